>>> design/ilir_pkg.sv
// ----------------------------------------------------------------------------
// ilir_pkg
// Shared types and constants for the indexed list with insert and remove.
// ----------------------------------------------------------------------------
`default_nettype none

package ilir_pkg;

    // default sizing of the list store
    localparam int DEF_CAPACITY   = 16;
    localparam int DEF_DATA_WIDTH = 32;

    // fixed field widths of the beats
    localparam int OP_W      = 3;
    localparam int POS_W     = 5;
    localparam int DIN_W     = 32;
    localparam int ST_W      = 2;
    localparam int DOUT_W    = 32;
    localparam int WHERE_W   = 4;
    localparam int CNT_F_W   = 5;

    // depth of the queue between front and back
    localparam int QDEPTH    = 2;

    typedef enum logic [OP_W-1:0] {
        OP_APPEND = 3'd0,
        OP_INSERT = 3'd1,
        OP_SET    = 3'd2,
        OP_REMOVE = 3'd3,
        OP_GET    = 3'd4
    } t_op;

    typedef enum logic [2:0] {
        K_APPEND,
        K_INSERT,
        K_SET,
        K_REMOVE,
        K_GET,
        K_BAD
    } t_kind;

    typedef enum logic [ST_W-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef struct packed {
        t_kind             kind;
        logic [POS_W-1:0]  pos;
    } t_req;

endpackage

`default_nettype wire

>>> design/indexed_list_insert_remove.sv
// ----------------------------------------------------------------------------
// indexed_list_insert_remove
// A request beat is registered in the front, then in the queue; the back
// executes it and registers its result. Throughput: one request per cycle
// unless stalled, as the cell row shifts all entries at once for any op.
// Reset: synchronous, clears the count and all valid flags; cells keep junk.
// ----------------------------------------------------------------------------
`default_nettype none

module indexed_list_insert_remove
    import ilir_pkg::*;
#(
    parameter int CAPACITY   = DEF_CAPACITY,
    parameter int DATA_WIDTH = DEF_DATA_WIDTH
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire logic [OP_W-1:0]     i_op,
    input  wire logic [POS_W-1:0]    i_position,
    input  wire logic [DIN_W-1:0]    i_data_in,
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output logic [ST_W-1:0]          o_status,
    output logic [DOUT_W-1:0]        o_data_out,
    output logic [WHERE_W-1:0]       o_where,
    output logic [CNT_F_W-1:0]       o_count_after
);

    logic                  f_push;
    t_req                  f_req;
    logic [DATA_WIDTH-1:0] f_data;
    logic                  q_full;
    logic                  q_valid;
    t_req                  q_req;
    logic [DATA_WIDTH-1:0] q_data;
    logic                  b_pop;

    ilir_front #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_op       (i_op),
        .i_position (i_position),
        .i_data_in  (i_data_in),
        .o_push     (f_push),
        .i_q_full   (q_full),
        .o_req      (f_req),
        .o_data     (f_data)
    );

    ilir_queue #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_req   (f_req),
        .i_data  (f_data),
        .o_full  (q_full),
        .i_pop   (b_pop),
        .o_valid (q_valid),
        .o_req   (q_req),
        .o_data  (q_data)
    );

    ilir_back #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (q_valid),
        .i_req         (q_req),
        .i_data        (q_data),
        .o_pop         (b_pop),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_status      (o_status),
        .o_data_out    (o_data_out),
        .o_where       (o_where),
        .o_count_after (o_count_after)
    );

endmodule

`default_nettype wire

>>> design/ilir_front.sv
// ----------------------------------------------------------------------------
// ilir_front
// Takes request beats, decodes the op code and trims the data word.
// ----------------------------------------------------------------------------
`default_nettype none

module ilir_front
    import ilir_pkg::*;
#(
    parameter int DATA_WIDTH = DEF_DATA_WIDTH
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire logic [OP_W-1:0]       i_op,
    input  wire logic [POS_W-1:0]      i_position,
    input  wire logic [DIN_W-1:0]      i_data_in,
    output logic                       o_push,
    input  wire logic                  i_q_full,
    output t_req                       o_req,
    output logic [DATA_WIDTH-1:0]      o_data
);

    logic                  r_valid;
    logic                  n_valid;
    t_req                  r_req;
    t_req                  n_req;
    logic [DATA_WIDTH-1:0] r_data;
    logic                  accept;

    assign o_in_stall = r_valid && i_q_full;
    assign accept     = i_in_valid && !o_in_stall;
    assign o_push     = r_valid && !i_q_full;

    always_comb begin
        n_req.pos = i_position;
        unique case (i_op)
            OP_APPEND: n_req.kind = K_APPEND;
            OP_INSERT: n_req.kind = K_INSERT;
            OP_SET:    n_req.kind = K_SET;
            OP_REMOVE: n_req.kind = K_REMOVE;
            OP_GET:    n_req.kind = K_GET;
            default:   n_req.kind = K_BAD;
        endcase
    end

    always_comb begin
        n_valid = r_valid;
        if (accept) begin
            n_valid = 1'b1;
        end else if (o_push) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req  <= n_req;
            r_data <= DATA_WIDTH'(i_data_in);
        end
    end

    assign o_req  = r_req;
    assign o_data = r_data;

endmodule

`default_nettype wire

>>> design/ilir_queue.sv
// ----------------------------------------------------------------------------
// ilir_queue
// Short FIFO of decoded requests between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module ilir_queue
    import ilir_pkg::*;
#(
    parameter int DATA_WIDTH = DEF_DATA_WIDTH
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_push,
    input  wire t_req                  i_req,
    input  wire logic [DATA_WIDTH-1:0] i_data,
    output logic                       o_full,
    input  wire logic                  i_pop,
    output logic                       o_valid,
    output t_req                       o_req,
    output logic [DATA_WIDTH-1:0]      o_data
);

    localparam int QP_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QF_W = $clog2(QDEPTH + 1);

    t_req                  r_req_mem  [QDEPTH];
    logic [DATA_WIDTH-1:0] r_data_mem [QDEPTH];
    logic [QP_W-1:0]       r_wr_ptr;
    logic [QP_W-1:0]       r_rd_ptr;
    logic [QF_W-1:0]       r_fill;
    logic [QP_W-1:0]       n_wr_ptr;
    logic [QP_W-1:0]       n_rd_ptr;
    logic [QF_W-1:0]       n_fill;
    logic                  do_push;
    logic                  do_pop;

    assign o_full  = (r_fill == QF_W'(QDEPTH));
    assign o_valid = (r_fill != '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_fill   = r_fill;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == QP_W'(QDEPTH - 1)) ? '0 : r_wr_ptr + QP_W'(1);
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == QP_W'(QDEPTH - 1)) ? '0 : r_rd_ptr + QP_W'(1);
        end
        if (do_push && !do_pop) begin
            n_fill = r_fill + QF_W'(1);
        end else if (do_pop && !do_push) begin
            n_fill = r_fill - QF_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_fill   <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_req_mem[r_wr_ptr]  <= i_req;
            r_data_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_req  = r_req_mem[r_rd_ptr];
    assign o_data = r_data_mem[r_rd_ptr];

endmodule

`default_nettype wire

>>> design/ilir_back.sv
// ----------------------------------------------------------------------------
// ilir_back
// Executes one request per cycle while the output is not stalled, on a shifting
// row of cells plus a count, and holds the result beat in an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ilir_back
    import ilir_pkg::*;
#(
    parameter int CAPACITY   = DEF_CAPACITY,
    parameter int DATA_WIDTH = DEF_DATA_WIDTH
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_q_valid,
    input  wire t_req                  i_req,
    input  wire logic [DATA_WIDTH-1:0] i_data,
    output logic                       o_pop,
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output logic [ST_W-1:0]            o_status,
    output logic [DOUT_W-1:0]          o_data_out,
    output logic [WHERE_W-1:0]         o_where,
    output logic [CNT_F_W-1:0]         o_count_after
);

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

    logic [DATA_WIDTH-1:0] r_cells [CAPACITY];
    logic [DATA_WIDTH-1:0] n_cells [CAPACITY];
    logic [CNT_W-1:0]      r_count;
    logic [CNT_W-1:0]      n_count;

    logic                  r_out_valid;
    t_status               r_status;
    logic [DOUT_W-1:0]     r_data_out;
    logic [WHERE_W-1:0]    r_where;
    logic [CNT_F_W-1:0]    r_count_after;

    logic                  fire;
    logic [CMP_W-1:0]      pos_c;
    logic [CMP_W-1:0]      cnt_c;
    logic                  is_full;
    t_status               st;
    logic                  wr_en;
    logic [CMP_W-1:0]      wr_idx;
    logic                  shift_up;
    logic                  shift_dn;
    logic                  rd_en;
    logic [DATA_WIDTH-1:0] rd_word;

    assign fire  = i_q_valid && (!r_out_valid || !i_out_stall);
    assign o_pop = fire;

    assign pos_c   = CMP_W'(i_req.pos);
    assign cnt_c   = CMP_W'(r_count);
    assign is_full = (r_count == CNT_W'(CAPACITY));
    assign rd_word = r_cells[pos_c[IDX_W-1:0]];

    always_comb begin
        st       = ST_RANGE;
        wr_en    = 1'b0;
        wr_idx   = cnt_c;
        shift_up = 1'b0;
        shift_dn = 1'b0;
        rd_en    = 1'b0;
        n_count  = r_count;
        unique case (i_req.kind)
            K_APPEND: begin
                if (is_full) begin
                    st = ST_FULL;
                end else begin
                    st      = ST_OK;
                    wr_en   = 1'b1;
                    n_count = r_count + CNT_W'(1);
                end
            end
            K_INSERT: begin
                if (pos_c > cnt_c) begin
                    st = ST_RANGE;
                end else if (is_full) begin
                    st = ST_FULL;
                end else begin
                    st       = ST_OK;
                    wr_en    = 1'b1;
                    wr_idx   = pos_c;
                    shift_up = 1'b1;
                    n_count  = r_count + CNT_W'(1);
                end
            end
            K_SET: begin
                // set at the end of the list behaves as append
                if (pos_c == cnt_c) begin
                    if (is_full) begin
                        st = ST_FULL;
                    end else begin
                        st      = ST_OK;
                        wr_en   = 1'b1;
                        n_count = r_count + CNT_W'(1);
                    end
                end else if (pos_c < cnt_c) begin
                    st     = ST_OK;
                    wr_en  = 1'b1;
                    wr_idx = pos_c;
                end
            end
            K_REMOVE: begin
                if (pos_c < cnt_c) begin
                    st       = ST_OK;
                    rd_en    = 1'b1;
                    shift_dn = 1'b1;
                    n_count  = r_count - CNT_W'(1);
                end
            end
            K_GET: begin
                if (pos_c < cnt_c) begin
                    st    = ST_OK;
                    rd_en = 1'b1;
                end
            end
            default: begin
                st = ST_RANGE;
            end
        endcase
    end

    // each cell picks hold, its lower neighbor, its upper neighbor or the new word
    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            n_cells[i] = r_cells[i];
        end
        if (shift_up) begin
            for (int i = 1; i < CAPACITY; i++) begin
                if (CMP_W'(i) > wr_idx) begin
                    n_cells[i] = r_cells[i-1];
                end
            end
        end
        if (shift_dn) begin
            for (int i = 0; i < CAPACITY - 1; i++) begin
                if (CMP_W'(i) >= pos_c) begin
                    n_cells[i] = r_cells[i+1];
                end
            end
        end
        if (wr_en) begin
            n_cells[wr_idx[IDX_W-1:0]] = i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            for (int i = 0; i < CAPACITY; i++) begin
                r_cells[i] <= n_cells[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (fire) begin
                r_count <= n_count;
            end
            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_status      <= st;
            r_data_out    <= rd_en ? DOUT_W'(rd_word) : '0;
            r_where       <= wr_en ? WHERE_W'(wr_idx) : '0;
            r_count_after <= CNT_F_W'(n_count);
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_status;
    assign o_data_out    = r_data_out;
    assign o_where       = r_where;
    assign o_count_after = r_count_after;

endmodule

`default_nettype wire

>>> test/indexed_list_insert_remove_tb.sv
// ----------------------------------------------------------------------------
// indexed_list_insert_remove_tb
// Self-checking bench for the indexed list. A short table of directed
// requests covers the empty and full list and the error codes, then random
// requests grow and shrink the list. Every result beat is checked against
// its table row or a local model. Both handshakes idle and stall at random.
// ----------------------------------------------------------------------------
module indexed_list_insert_remove_tb;
    import ilir_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIST_DEPTH   = DEF_CAPACITY;
    localparam int RANDOM_ITEMS = 1800;
    localparam int CALM_FIRST   = 700;
    localparam int CALM_LAST    = 1099;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 8;
    localparam int PRINT_CAP    = 40;

    // op codes the block does not decode
    localparam logic [OP_W-1:0] OP_RSVD_5 = 3'd5;
    localparam logic [OP_W-1:0] OP_RSVD_6 = 3'd6;
    localparam logic [OP_W-1:0] OP_RSVD_7 = 3'd7;

    typedef struct packed {
        t_status             status;
        logic [DOUT_W-1:0]   rd_word;
        logic [WHERE_W-1:0]  slot;
        logic [CNT_F_W-1:0]  count_after;
    } t_result;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [POS_W-1:0]  pos;
        logic [DIN_W-1:0]  word;
        logic [4:0]        reps;
        logic              typed;
        t_result           res;
    } t_vec;

    localparam t_vec DIRECTED_ROWS [23] = '{
        // empty list: every indexed access is out of range
        '{OP_GET,    5'd0,  32'h0000_0000, 5'd1,  1'b1, '{ST_RANGE, 32'h0, 4'd0, 5'd0}},
        '{OP_REMOVE, 5'd0,  32'h0000_0000, 5'd1,  1'b1, '{ST_RANGE, 32'h0, 4'd0, 5'd0}},
        '{OP_INSERT, 5'd1,  32'hFFFF_FFFF, 5'd1,  1'b1, '{ST_RANGE, 32'h0, 4'd0, 5'd0}},
        '{OP_SET,    5'd1,  32'hFFFF_FFFF, 5'd1,  1'b1, '{ST_RANGE, 32'h0, 4'd0, 5'd0}},
        '{OP_RSVD_7, 5'd31, 32'hFFFF_FFFF, 5'd1,  1'b1, '{ST_RANGE, 32'h0, 4'd0, 5'd0}},
        '{OP_APPEND, 5'd0,  32'hFFFF_FFFF, 5'd1,  1'b1, '{ST_OK,    32'h0, 4'd0, 5'd1}},
        '{OP_INSERT, 5'd0,  32'h0000_0000, 5'd1,  1'b1, '{ST_OK,    32'h0, 4'd0, 5'd2}},
        // set at the tail appends
        '{OP_SET,    5'd2,  32'hA5A5_A5A5, 5'd1,  1'b1, '{ST_OK,    32'h0, 4'd2, 5'd3}},
        '{OP_SET,    5'd1,  32'h5A5A_5A5A, 5'd1,  1'b1, '{ST_OK,    32'h0, 4'd1, 5'd3}},
        '{OP_INSERT, 5'd1,  32'h1234_5678, 5'd1,  1'b0, '0},
        '{OP_GET,    5'd2,  32'h0000_0000, 5'd1,  1'b0, '0},
        '{OP_REMOVE, 5'd0,  32'h0000_0000, 5'd1,  1'b0, '0},
        '{OP_RSVD_5, 5'd3,  32'h0000_0000, 5'd1,  1'b1, '{ST_RANGE, 32'h0, 4'd0, 5'd3}},
        // fill up to capacity
        '{OP_APPEND, 5'd0,  32'h8000_0001, 5'd13, 1'b0, '0},
        '{OP_APPEND, 5'd0,  32'hDEAD_BEEF, 5'd1,  1'b1, '{ST_FULL,  32'h0, 4'd0, 5'd16}},
        '{OP_INSERT, 5'd0,  32'h0000_0001, 5'd1,  1'b1, '{ST_FULL,  32'h0, 4'd0, 5'd16}},
        // range check wins over full
        '{OP_INSERT, 5'd17, 32'h0000_0001, 5'd1,  1'b1, '{ST_RANGE, 32'h0, 4'd0, 5'd16}},
        '{OP_SET,    5'd16, 32'h0000_0001, 5'd1,  1'b1, '{ST_FULL,  32'h0, 4'd0, 5'd16}},
        '{OP_SET,    5'd31, 32'h0000_0001, 5'd1,  1'b1, '{ST_RANGE, 32'h0, 4'd0, 5'd16}},
        '{OP_GET,    5'd15, 32'h0000_0000, 5'd1,  1'b0, '0},
        '{OP_REMOVE, 5'd16, 32'h0000_0000, 5'd1,  1'b1, '{ST_RANGE, 32'h0, 4'd0, 5'd16}},
        '{OP_REMOVE, 5'd15, 32'h0000_0000, 5'd1,  1'b0, '0},
        '{OP_RSVD_6, 5'd1,  32'h0000_0000, 5'd1,  1'b1, '{ST_RANGE, 32'h0, 4'd0, 5'd15}}
    };

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                req_valid = 1'b0;
    logic                req_stall;
    logic [OP_W-1:0]     req_op = '0;
    logic [POS_W-1:0]    req_pos = '0;
    logic [DIN_W-1:0]    req_word = '0;
    logic                rsp_valid;
    logic                rsp_stall = 1'b0;
    logic [ST_W-1:0]     rsp_status;
    logic [DOUT_W-1:0]   rsp_word;
    logic [WHERE_W-1:0]  rsp_slot;
    logic [CNT_F_W-1:0]  rsp_count;

    logic [DIN_W-1:0]    list_words [LIST_DEPTH];
    int unsigned         list_fill = 0;
    t_result             awaited_results [$];

    bit                  calm = 1'b0;
    int unsigned         cycles = 0;
    int unsigned         err_count = 0;
    int unsigned         sent = 0;
    int unsigned         checked = 0;
    int unsigned         full_hits = 0;
    int unsigned         bad_ops = 0;

    indexed_list_insert_remove i_dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (req_valid),
        .o_in_stall    (req_stall),
        .i_op          (req_op),
        .i_position    (req_pos),
        .i_data_in     (req_word),
        .o_out_valid   (rsp_valid),
        .i_out_stall   (rsp_stall),
        .o_status      (rsp_status),
        .o_data_out    (rsp_word),
        .o_where       (rsp_slot),
        .o_count_after (rsp_count)
    );

    always begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Applies one request to the local list and returns its result beat.
    function automatic t_result apply_list_op(input logic [OP_W-1:0] op,
                                              input logic [POS_W-1:0] pos,
                                              input logic [DIN_W-1:0] word);
        t_result     r;
        int unsigned p;
        int unsigned i;
        r = '0;
        r.status = ST_RANGE;
        p = pos;
        if (op == OP_APPEND || (op == OP_SET && p == list_fill)) begin
            if (list_fill >= LIST_DEPTH) begin
                r.status = ST_FULL;
            end else begin
                list_words[list_fill] = word;
                r.slot = list_fill[WHERE_W-1:0];
                list_fill++;
                r.status = ST_OK;
            end
        end else begin
            case (op)
                OP_INSERT: begin
                    if (p > list_fill) begin
                        r.status = ST_RANGE;
                    end else if (list_fill >= LIST_DEPTH) begin
                        r.status = ST_FULL;
                    end else begin
                        for (i = list_fill; i > p; i--)
                            list_words[i] = list_words[i-1];
                        list_words[p] = word;
                        list_fill++;
                        r.slot = p[WHERE_W-1:0];
                        r.status = ST_OK;
                    end
                end
                OP_SET: begin
                    if (p < list_fill) begin
                        list_words[p] = word;
                        r.slot = p[WHERE_W-1:0];
                        r.status = ST_OK;
                    end
                end
                OP_REMOVE: begin
                    if (p < list_fill) begin
                        r.rd_word = list_words[p];
                        list_fill--;
                        for (i = p; i < list_fill; i++)
                            list_words[i] = list_words[i+1];
                        r.status = ST_OK;
                    end
                end
                OP_GET: begin
                    if (p < list_fill) begin
                        r.rd_word = list_words[p];
                        r.status = ST_OK;
                    end
                end
                default: bad_ops++;
            endcase
        end
        if (r.status == ST_FULL)
            full_hits++;
        if (r.status != ST_OK)
            r.slot = '0;
        r.count_after = list_fill[CNT_F_W-1:0];
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        if (err_count < PRINT_CAP)
            $display("%0t mismatch: %s", $time, msg);
        err_count++;
    endtask

    // One request beat; the result is queued once the beat is taken.
    task automatic send_request(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
                                input logic [DIN_W-1:0] word, input logic typed,
                                input t_result typed_res);
        t_result predicted;
        if (!calm && $urandom_range(0, 99) < 9) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        req_valid <= 1'b1;
        req_op    <= op;
        req_pos   <= pos;
        req_word  <= word;
        do @(posedge clk); while (req_stall);
        predicted = apply_list_op(op, pos, word);
        awaited_results.push_back(typed ? typed_res : predicted);
        sent++;
    endtask

    always @(posedge clk)
        rsp_stall <= calm ? 1'b0 : ($urandom_range(0, 99) < 9);

    always @(posedge clk) begin
        t_result want;
        if (rst_n && rsp_valid && !rsp_stall) begin
            if (awaited_results.size() == 0) begin
                report_mismatch($sformatf("result beat with nothing outstanding, status %0d",
                                          rsp_status));
            end else begin
                want = awaited_results.pop_front();
                checked++;
                if (rsp_status !== want.status)
                    report_mismatch($sformatf("status exp %0d got %0d",
                                              want.status, rsp_status));
                if (rsp_word !== want.rd_word)
                    report_mismatch($sformatf("data_out exp %h got %h",
                                              want.rd_word, rsp_word));
                if (rsp_slot !== want.slot)
                    report_mismatch($sformatf("where exp %0d got %0d", want.slot, rsp_slot));
                if (rsp_count !== want.count_after)
                    report_mismatch($sformatf("count_after exp %0d got %0d",
                                              want.count_after, rsp_count));
            end
        end
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, awaited_results.size());
            $display("[indexed_list_insert_remove] ERROR");
            $finish;
        end
    end

    initial begin
        logic [OP_W-1:0]  op;
        logic [POS_W-1:0] pos;
        logic [DIN_W-1:0] word;
        int unsigned      roll;
        bit               grow;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        foreach (DIRECTED_ROWS[n]) begin
            for (int r = 0; r < DIRECTED_ROWS[n].reps; r++)
                send_request(DIRECTED_ROWS[n].op, DIRECTED_ROWS[n].pos,
                             DIRECTED_ROWS[n].word + r, DIRECTED_ROWS[n].typed,
                             DIRECTED_ROWS[n].res);
        end

        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            calm = (k >= CALM_FIRST && k <= CALM_LAST);
            // alternate growing and shrinking stretches so full and empty recur
            grow = ((k / 120) % 2) == 0;
            roll = $urandom_range(0, 99);
            if (roll < 4)
                op = OP_W'($urandom_range(int'(OP_RSVD_5), int'(OP_RSVD_7)));
            else if (roll < (grow ? 29 : 12))
                op = OP_APPEND;
            else if (roll < (grow ? 54 : 20))
                op = OP_INSERT;
            else if (roll < (grow ? 69 : 32))
                op = OP_SET;
            else if (roll < (grow ? 84 : 77))
                op = OP_REMOVE;
            else
                op = OP_GET;
            if ($urandom_range(0, 99) < 85)
                pos = POS_W'($urandom_range(0, list_fill));
            else
                pos = POS_W'($urandom_range(0, (1 << POS_W) - 1));
            case ($urandom_range(0, 19))
                0:       word = '0;
                1:       word = '1;
                default: word = $urandom;
            endcase
            send_request(op, pos, word, 1'b0, '0);
        end
        calm = 1'b0;
        req_valid <= 1'b0;

        while (awaited_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("sent %0d requests (%0d with undecoded ops), checked %0d results",
                 sent, bad_ops, checked);
        $display("list full rejections: %0d, mismatches: %0d", full_hits, err_count);
        if (err_count == 0) begin
            $display("[indexed_list_insert_remove] OK");
        end else begin
            $display("[indexed_list_insert_remove] ERROR");
        end
        $finish;
    end

endmodule

>>> indexed_list_insert_remove.f
design/ilir_pkg.sv
design/ilir_front.sv
design/ilir_queue.sv
design/ilir_back.sv
design/indexed_list_insert_remove.sv
test/indexed_list_insert_remove_tb.sv
